/* rtl/tbpr_pkg.sv */
// ----------------------------------------------------------------------------
// tbpr_pkg
// shared types, codes and the master colour table of the background renderer
// ----------------------------------------------------------------------------
package tbpr_pkg;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_RENDER = 1'b1;

   localparam logic [1:0]  BUS_REGION_PATTERN = 2'b01;
   localparam logic [1:0]  BUS_REGION_NAMES   = 2'b10;
   localparam logic [5:0]  BUS_PAGE_PALETTE   = 6'h3F;
   localparam logic [11:0] ATTR_OFFSET        = 12'h3C0;
   localparam logic [5:0]  ROWS_PER_TABLE     = 6'd30;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_NAME,
      ST_PIXELS
   } state_type;

   typedef struct packed {
      logic        en;
      logic [13:0] addr;
      logic [7:0]  data;
   } bus_wr_type;

   typedef struct packed {
      logic        en;
      logic [11:0] addr_a;
      logic [11:0] addr_b;
   } rd_pair_type;

   localparam logic [23:0] MASTER_COLOURS [64] = '{
      24'h7C7C7C, 24'h0000FC, 24'h0000BC, 24'h4428BC,
      24'h940084, 24'hA80020, 24'hA81000, 24'h881400,
      24'h503000, 24'h007800, 24'h006800, 24'h005800,
      24'h004058, 24'h000000, 24'h000000, 24'h000000,
      24'hBCBCBC, 24'h0078F8, 24'h0058F8, 24'h6844FC,
      24'hD800CC, 24'hE40058, 24'hF83800, 24'hE45C10,
      24'hAC7C00, 24'h00B800, 24'h00A800, 24'h00A844,
      24'h008888, 24'h000000, 24'h000000, 24'h000000,
      24'hF8F8F8, 24'h3CBCFC, 24'h6888FC, 24'h9878F8,
      24'hF878F8, 24'hF85898, 24'hF87858, 24'hFCA044,
      24'hF8B800, 24'hB8F818, 24'h58D854, 24'h58F898,
      24'h00E8D8, 24'h787878, 24'h000000, 24'h000000,
      24'hFCFCFC, 24'hA4E4FC, 24'hB8B8F8, 24'hD8B8F8,
      24'hF8B8F8, 24'hF8A4C0, 24'hF0D0B0, 24'hFCE0A8,
      24'hF8D878, 24'hD8F878, 24'hB8F8B8, 24'hB8F8D8,
      24'h00FCFC, 24'hF8D8F8, 24'h000000, 24'h000000
   };

endpackage

/* rtl/tbpr_vram.sv */
// ----------------------------------------------------------------------------
// tbpr_vram
// pattern and name table memories, one decoded write port and two read ports
// each, read data registered
// ----------------------------------------------------------------------------
module tbpr_vram
   import tbpr_pkg::*;
(
   input  logic        clock,
   input  bus_wr_type  wr,
   input  rd_pair_type nt_rd,
   input  rd_pair_type pat_rd,
   output logic [7:0]  nt_q_a,
   output logic [7:0]  nt_q_b,
   output logic [7:0]  pat_q_a,
   output logic [7:0]  pat_q_b
);

   logic [7:0] pattern_mem_ff [4096];
   logic [7:0] names_mem_ff [4096];
   logic [7:0] nt_q_a_ff;
   logic [7:0] nt_q_b_ff;
   logic [7:0] pat_q_a_ff;
   logic [7:0] pat_q_b_ff;
   logic       pat_we;
   logic       nt_we;

   assign pat_we = wr.en && (wr.addr[13:12] == BUS_REGION_PATTERN);
   assign nt_we  = wr.en && (wr.addr[13:12] == BUS_REGION_NAMES);

   always_ff @(posedge clock) begin
      if (pat_we) begin
         pattern_mem_ff[wr.addr[11:0]] <= wr.data;
      end
      if (pat_rd.en) begin
         pat_q_a_ff <= pattern_mem_ff[pat_rd.addr_a];
         pat_q_b_ff <= pattern_mem_ff[pat_rd.addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (nt_we) begin
         names_mem_ff[wr.addr[11:0]] <= wr.data;
      end
      if (nt_rd.en) begin
         nt_q_a_ff <= names_mem_ff[nt_rd.addr_a];
         nt_q_b_ff <= names_mem_ff[nt_rd.addr_b];
      end
   end

   assign nt_q_a  = nt_q_a_ff;
   assign nt_q_b  = nt_q_b_ff;
   assign pat_q_a = pat_q_a_ff;
   assign pat_q_b = pat_q_b_ff;

endmodule

/* rtl/tbpr_palette.sv */
// ----------------------------------------------------------------------------
// tbpr_palette
// palette memory with entry mirroring on write and a registered read
// ----------------------------------------------------------------------------
module tbpr_palette
   import tbpr_pkg::*;
(
   input  logic       clock,
   input  bus_wr_type wr,
   input  logic       rd_en,
   input  logic [4:0] rd_addr,
   output logic [5:0] rd_q
);

   logic [5:0] palette_mem_ff [32];
   logic [5:0] rd_q_ff;
   logic [4:0] wr_entry;
   logic       we;

   assign we = wr.en && (wr.addr[13:8] == BUS_PAGE_PALETTE);

   // backdrop mirrors of the sprite palettes
   always_comb begin
      wr_entry = wr.addr[4:0];
      if (wr_entry[4] && (wr_entry[1:0] == 2'b00)) begin
         wr_entry[4] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         palette_mem_ff[wr_entry] <= wr.data[5:0];
      end
      if (rd_en) begin
         rd_q_ff <= palette_mem_ff[rd_addr];
      end
   end

   assign rd_q = rd_q_ff;

endmodule

/* rtl/tile_background_pixel_render.sv */
// a render pixel passes the name table read, pattern read, palette read and output register
// throughput: one pixel per cycle while the output is not stalled; a render transaction holds the input
//   busy for its name table read, pattern read, then eight palette reads in the palette memory
// a write transaction gives no result and leaves the input ready
// reset clears the sequencer and the output valid flag; memories and data registers are not cleared
// ----------------------------------------------------------------------------
// tile_background_pixel_render
// background tile line renderer over pattern, name table and palette memories
// ----------------------------------------------------------------------------
module tile_background_pixel_render
   import tbpr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [13:0] req_write_address,
   input  logic [7:0]  req_write_data,
   input  logic [5:0]  req_tile_row,
   input  logic [5:0]  req_tile_col,
   input  logic [2:0]  req_pixel_row,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [8:0]  rsp_pixel_x,
   output logic [8:0]  rsp_pixel_y,
   output logic        rsp_last_pixel
);

   state_type   state_ff, state_in;
   logic [3:0]  issue_cnt_ff, issue_cnt_in;
   logic        pq_valid_ff, pq_valid_in;
   logic [2:0]  pq_k_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [5:0]  trow_ff;
   logic [5:0]  tcol_ff;
   logic [2:0]  prow_ff;
   logic [1:0]  quad_ff;
   logic [1:0]  pal_ff;
   logic [23:0] rgb_ff;
   logic [8:0]  pixel_x_ff;
   logic [8:0]  pixel_y_ff;
   logic        last_ff;

   bus_wr_type  wr;
   rd_pair_type nt_rd;
   rd_pair_type pat_rd;
   logic [7:0]  nt_q_a, nt_q_b, pat_q_a, pat_q_b;
   logic        pal_rd_en;
   logic [4:0]  pal_rd_addr;
   logic [5:0]  pal_q;

   logic        accept;
   logic        out_free, load_out, pq_free, issue;
   logic        lower;
   logic [5:0]  lrow;
   logic [4:0]  lcol;
   logic [11:0] table_base;
   logic [1:0]  pal_sel;
   logic [2:0]  bit_sel;
   logic [1:0]  px;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   assign wr.en   = accept && (req_opcode == OP_WRITE);
   assign wr.addr = req_write_address;
   assign wr.data = req_write_data;

   // local coordinates inside the 2x2 name table layout
   assign lower      = (req_tile_row >= ROWS_PER_TABLE);
   assign lrow       = lower ? (req_tile_row - ROWS_PER_TABLE) : req_tile_row;
   assign lcol       = req_tile_col[4:0];
   assign table_base = {lower, req_tile_col[5], 10'd0};

   assign nt_rd.en     = accept && (req_opcode == OP_RENDER);
   assign nt_rd.addr_a = table_base + 12'({lrow, 5'd0}) + 12'(lcol);
   assign nt_rd.addr_b = table_base + ATTR_OFFSET + 12'({lrow[5:2], 3'd0}) + 12'(lcol[4:2]);

   assign pat_rd.en     = (state_ff == ST_NAME);
   assign pat_rd.addr_a = {nt_q_a, 1'b0, prow_ff};
   assign pat_rd.addr_b = {nt_q_a, 1'b1, prow_ff};

   always_comb begin
      case (quad_ff)
         2'b00:   pal_sel = nt_q_b[1:0];
         2'b01:   pal_sel = nt_q_b[3:2];
         2'b10:   pal_sel = nt_q_b[5:4];
         2'b11:   pal_sel = nt_q_b[7:6];
         default: pal_sel = nt_q_b[1:0];
      endcase
   end

   assign bit_sel     = 3'd7 - issue_cnt_ff[2:0];
   assign px          = {pat_q_b[bit_sel], pat_q_a[bit_sel]};
   assign pal_rd_addr = (px == 2'b00) ? 5'd0 : {1'b0, pal_ff, px};

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign load_out  = pq_valid_ff && out_free;
   assign pq_free   = !pq_valid_ff || load_out;
   assign issue     = (state_ff == ST_PIXELS) && !issue_cnt_ff[3] && pq_free;
   assign pal_rd_en = issue;

   always_comb begin
      state_in     = state_ff;
      issue_cnt_in = issue_cnt_ff;
      pq_valid_in  = pq_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (issue) begin
         pq_valid_in  = 1'b1;
         issue_cnt_in = issue_cnt_ff + 4'd1;
      end else if (load_out) begin
         pq_valid_in = 1'b0;
      end
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_opcode == OP_RENDER)) begin
               state_in     = ST_NAME;
               issue_cnt_in = 4'd0;
            end
         end
         ST_NAME: begin
            state_in = ST_PIXELS;
         end
         ST_PIXELS: begin
            if (issue_cnt_ff[3] && pq_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_cnt_ff <= 4'd0;
         pq_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_cnt_ff <= issue_cnt_in;
         pq_valid_ff  <= pq_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (nt_rd.en) begin
         trow_ff <= req_tile_row;
         tcol_ff <= req_tile_col;
         prow_ff <= req_pixel_row;
         quad_ff <= {lrow[1], lcol[1]};
      end
      if (state_ff == ST_NAME) begin
         pal_ff <= pal_sel;
      end
      if (issue) begin
         pq_k_ff <= issue_cnt_ff[2:0];
      end
      if (load_out) begin
         rgb_ff     <= MASTER_COLOURS[pal_q];
         pixel_x_ff <= {tcol_ff, pq_k_ff};
         pixel_y_ff <= {trow_ff, prow_ff};
         last_ff    <= (pq_k_ff == 3'd7);
      end
   end

   tbpr_vram u_vram (
      .clock   (clock),
      .wr      (wr),
      .nt_rd   (nt_rd),
      .pat_rd  (pat_rd),
      .nt_q_a  (nt_q_a),
      .nt_q_b  (nt_q_b),
      .pat_q_a (pat_q_a),
      .pat_q_b (pat_q_b)
   );

   tbpr_palette u_palette (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (pal_rd_en),
      .rd_addr (pal_rd_addr),
      .rd_q    (pal_q)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red        = rgb_ff[23:16];
   assign rsp_green      = rgb_ff[15:8];
   assign rsp_blue       = rgb_ff[7:0];
   assign rsp_pixel_x    = pixel_x_ff;
   assign rsp_pixel_y    = pixel_y_ff;
   assign rsp_last_pixel = last_ff;

endmodule

/* rtl/tbpr_checker.sv */
// ----------------------------------------------------------------------------
// tbpr_checker
// port level checks of the background renderer, bound to the top level
// ----------------------------------------------------------------------------
module tbpr_checker
   import tbpr_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_opcode,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_red,
   input logic [7:0] rsp_green,
   input logic [7:0] rsp_blue,
   input logic [8:0] rsp_pixel_x,
   input logic [8:0] rsp_pixel_y,
   input logic       rsp_last_pixel
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_red, rsp_green, rsp_blue,
         rsp_pixel_x, rsp_pixel_y, rsp_last_pixel}))
      else $error("result changed while stalled");

   // render transaction blocks the input
   a_render_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_opcode == OP_RENDER) |=> !req_ready)
      else $error("input ready right after render transaction");

   // write transaction keeps the input open
   a_write_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_opcode == OP_WRITE) |=> req_ready)
      else $error("input not ready after write transaction");

   // last pixel sits at the right edge of the tile
   a_last_edge: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_pixel == (rsp_pixel_x[2:0] == 3'd7)))
      else $error("last pixel flag does not match pixel position");

endmodule

bind tile_background_pixel_render tbpr_checker u_checker (.*);
